>>> rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// TFTP session tracker package
// Shared constants, codes and record types for the session tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int SESSION_SLOTS = 16;
	localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

	localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;
	localparam logic [15:0] MIN_PACKET_LEN = 16'd2;
	localparam logic [15:0] DATA_HDR_LEN = 16'd4;

	localparam logic [15:0] OP_RRQ = 16'd1;
	localparam logic [15:0] OP_WRQ = 16'd2;
	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_ACK = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_READING = 3'd1,
		ST_WRITING = 3'd2,
		ST_DONE = 3'd3,
		ST_ERROR = 3'd4
	} sess_state_t;

	typedef enum logic [1:0] {
		OUT_HANDLED = 2'd0,
		OUT_SHORT = 2'd1,
		OUT_FULL = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		OPEN_NONE = 2'd0,
		OPEN_READ = 2'd1,
		OPEN_WRITE = 2'd2
	} open_act_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_LOOKUP,
		CS_SELECT,
		CS_UPDATE
	} ctl_state_t;

	typedef struct packed {
		sess_state_t state;
		logic [15:0] block;
		logic file_open;
	} sess_rec_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic lookup;
		logic write;
		logic create;
		sess_rec_t rec;
	} cell_cmd_t;

	// Status returned from one cell to the controller.
	typedef struct packed {
		logic used;
		logic hit;
		logic head;
		sess_rec_t rec;
	} cell_stat_t;

endpackage

>>> rtl/tftp_session_tracker.sv
// ----------------------------------------------------------------------------
// TFTP session tracker
// Tracks up to SESSION_SLOTS peer sessions and reports file actions per packet.
// ----------------------------------------------------------------------------
// A packet's result is offered once the lookup, select and update steps have run
// in turn over the row of session cells; the update waits while an earlier
// result still sits untaken, and a new packet is taken only after the update retires.
// A new packet is taken while the previous result still waits to be taken.
// Reset clears the session table occupancy and sets block_size to 512.
module tftp_session_tracker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] peer_address,
	input logic [15:0] udp_port,
	input logic [15:0] opcode,
	input logic [15:0] block_number,
	input logic [15:0] payload_length,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] outcome,
	output logic [3:0] session_index,
	output logic session_created,
	output logic [2:0] session_state,
	output logic [15:0] current_block,
	output logic [1:0] open_action,
	output logic write_block,
	output logic [15:0] write_length,
	output logic close_file
);
	import tst_pkg::*;

	// Configuration register.
	logic [15:0] block_size_q;

	// Controller state.
	ctl_state_t cs_q, cs_d;

	// The packet being worked on, captured at its transaction.
	logic [31:0] pkt_address_q;
	logic [15:0] pkt_port_q;
	logic [15:0] pkt_opcode_q;
	logic [15:0] pkt_block_q;
	logic [15:0] pkt_length_q;

	// Lookup summary from the select step.
	sess_rec_t sel_rec_q;
	logic [SLOT_W-1:0] sel_index_q;
	logic sel_hit_q;
	logic sel_full_q;

	// Cell row.
	cell_cmd_t cmd;
	cell_stat_t stat [SESSION_SLOTS];
	logic [SESSION_SLOTS-1:0] used_vec;
	logic [SESSION_SLOTS-1:0] hit_vec;
	logic [SESSION_SLOTS:0] used_chain;

	// Select step results.
	sess_rec_t any_rec;
	logic [SLOT_W-1:0] hit_index;
	logic [SLOT_W-1:0] head_index;

	// Update step results.
	sess_rec_t upd_rec;
	open_act_t upd_open;
	logic upd_write;
	logic [15:0] upd_wlen;
	logic upd_close;
	logic pkt_short;
	logic create;
	logic finish;

	// Output register.
	logic out_valid_q;
	outcome_t outcome_q;
	logic [3:0] session_index_q;
	logic session_created_q;
	sess_state_t session_state_q;
	logic [15:0] current_block_q;
	open_act_t open_action_q;
	logic write_block_q;
	logic [15:0] write_length_q;
	logic close_file_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			block_size_q <= cfg_wdata;
		end
	end

	// Each cell learns whether every slot below it is taken from its
	// neighbor, so the first free cell is the one allocation writes into.
	assign used_chain[0] = 1'b1;

	for (genvar i = 0; i < SESSION_SLOTS; i++) begin : g_cell
		tst_cell u_cell (
			.clk (clk),
			.arst_n (arst_n),
			.pkt_address (pkt_address_q),
			.pkt_port (pkt_port_q),
			.prev_used (used_chain[i]),
			.cmd (cmd),
			.stat (stat[i])
		);
		assign used_chain[i+1] = stat[i].used;
		assign used_vec[i] = stat[i].used;
		assign hit_vec[i] = stat[i].hit;
	end

	// A peer is appended only on a miss, so at most one cell hits and the
	// records and indexes can simply be ORed together.
	always_comb begin
		any_rec = '0;
		hit_index = '0;
		head_index = '0;
		for (int i = 0; i < SESSION_SLOTS; i++) begin
			any_rec = any_rec | stat[i].rec;
			if (stat[i].hit) begin
				hit_index = hit_index | SLOT_W'(i);
			end
			if (stat[i].head) begin
				head_index = head_index | SLOT_W'(i);
			end
		end
	end

	tst_update u_update (
		.opcode (pkt_opcode_q),
		.block_number (pkt_block_q),
		.payload_length (pkt_length_q),
		.block_size (block_size_q),
		.rec_in (sel_rec_q),
		.rec_out (upd_rec),
		.open_action (upd_open),
		.write_block (upd_write),
		.write_length (upd_wlen),
		.close_file (upd_close)
	);

	assign pkt_short = pkt_length_q < MIN_PACKET_LEN;
	assign create = !pkt_short && !sel_hit_q && !sel_full_q;
	// The update retires only when the output register is free or emptying.
	assign finish = (cs_q == CS_UPDATE) && (!out_valid_q || out_ready);

	// Next-state logic.
	always_comb begin
		cs_d = cs_q;
		unique case (cs_q)
			CS_IDLE: begin
				if (in_valid) begin
					cs_d = CS_LOOKUP;
				end
			end
			CS_LOOKUP: cs_d = CS_SELECT;
			CS_SELECT: cs_d = CS_UPDATE;
			CS_UPDATE: begin
				if (finish) begin
					cs_d = CS_IDLE;
				end
			end
			default: cs_d = CS_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_ready = 1'b0;
		cmd.lookup = 1'b0;
		cmd.write = 1'b0;
		cmd.create = create;
		cmd.rec = upd_rec;
		unique case (cs_q)
			CS_IDLE: in_ready = 1'b1;
			CS_LOOKUP: cmd.lookup = 1'b1;
			CS_SELECT: begin
			end
			CS_UPDATE: cmd.write = finish && !pkt_short && (sel_hit_q || create);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			cs_q <= cs_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_address_q <= peer_address;
			pkt_port_q <= udp_port;
			pkt_opcode_q <= opcode;
			pkt_block_q <= block_number;
			pkt_length_q <= payload_length;
		end
		if (cs_q == CS_SELECT) begin
			sel_rec_q <= any_rec;
			sel_hit_q <= |hit_vec;
			sel_full_q <= used_vec[SESSION_SLOTS-1];
			sel_index_q <= (|hit_vec) ? hit_index : head_index;
		end
		if (finish) begin
			// Dropped packets report their outcome with every other field zero.
			if (pkt_short || !(sel_hit_q || create)) begin
				outcome_q <= pkt_short ? OUT_SHORT : OUT_FULL;
				session_index_q <= '0;
				session_created_q <= 1'b0;
				session_state_q <= ST_IDLE;
				current_block_q <= '0;
				open_action_q <= OPEN_NONE;
				write_block_q <= 1'b0;
				write_length_q <= '0;
				close_file_q <= 1'b0;
			end else begin
				outcome_q <= OUT_HANDLED;
				session_index_q <= 4'(sel_index_q);
				session_created_q <= create;
				session_state_q <= upd_rec.state;
				current_block_q <= upd_rec.block;
				open_action_q <= upd_open;
				write_block_q <= upd_write;
				write_length_q <= upd_wlen;
				close_file_q <= upd_close;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign session_index = session_index_q;
	assign session_created = session_created_q;
	assign session_state = session_state_q;
	assign current_block = current_block_q;
	assign open_action = open_action_q;
	assign write_block = write_block_q;
	assign write_length = write_length_q;
	assign close_file = close_file_q;

	// No peer may ever sit in two slots.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one session cell matched the packet");

	// Occupied slots always form a solid run starting at slot zero.
	a_used_run: assert property (@(posedge clk) disable iff (!arst_n)
		((used_vec >> 1) & ~used_vec) == '0)
		else $error("session occupancy has a gap");

	// A newly created slot is only reported for a handled packet.
	a_created_handled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && session_created) |-> (outcome == OUT_HANDLED))
		else $error("session created on a dropped packet");

	// A stored block only comes from a session that is writing or just ended.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_block) |->
		(session_state == ST_WRITING || session_state == ST_DONE))
		else $error("data write reported outside a write transfer");

	// A held result, as seen on current_block, must not change while it waits to be taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(current_block)))
		else $error("pending result changed before it was taken");

endmodule

>>> rtl/tst_cell.sv
// ----------------------------------------------------------------------------
// Session cell
// Holds one session slot, compares it against the current packet and hands
// its occupancy to the next cell so the first free slot finds itself.
// ----------------------------------------------------------------------------
module tst_cell (
	input logic clk,
	input logic arst_n,
	input logic [31:0] pkt_address,
	input logic [15:0] pkt_port,
	input logic prev_used,
	input tst_pkg::cell_cmd_t cmd,
	output tst_pkg::cell_stat_t stat
);
	import tst_pkg::*;

	logic [31:0] address_q;
	logic [15:0] port_q;
	sess_rec_t rec_q;
	logic used_q;
	logic hit_q;
	logic head_q;
	logic sel;

	assign sel = hit_q || (cmd.create && head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			hit_q <= 1'b0;
			head_q <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				hit_q <= used_q && (address_q == pkt_address) && (port_q == pkt_port);
				// The occupied cells form a solid run from cell zero.
				head_q <= prev_used && !used_q;
			end
			if (cmd.write && cmd.create && head_q) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && sel) begin
			rec_q <= cmd.rec;
		end
		if (cmd.write && cmd.create && head_q) begin
			address_q <= pkt_address;
			port_q <= pkt_port;
		end
	end

	always_comb begin
		stat.used = used_q;
		stat.hit = hit_q;
		stat.head = head_q;
		stat.rec = hit_q ? rec_q : '0;
	end

endmodule

>>> rtl/tst_update.sv
// ----------------------------------------------------------------------------
// Session update
// Advances one session record for one packet and derives the file actions.
// ----------------------------------------------------------------------------
module tst_update (
	input logic [15:0] opcode,
	input logic [15:0] block_number,
	input logic [15:0] payload_length,
	input logic [15:0] block_size,
	input tst_pkg::sess_rec_t rec_in,
	output tst_pkg::sess_rec_t rec_out,
	output tst_pkg::open_act_t open_action,
	output logic write_block,
	output logic [15:0] write_length,
	output logic close_file
);
	import tst_pkg::*;

	logic [15:0] store_len;
	logic next_ok;

	assign store_len = payload_length - DATA_HDR_LEN;
	// The expected block does not wrap, so block 65535 accepts nothing more.
	assign next_ok = ({1'b0, block_number} == ({1'b0, rec_in.block} + 17'd1));

	always_comb begin
		rec_out = rec_in;
		open_action = OPEN_NONE;
		write_block = 1'b0;
		write_length = '0;
		close_file = 1'b0;
		unique case (opcode) inside
			OP_RRQ: begin
				rec_out.state = ST_READING;
				rec_out.block = 16'd1;
				rec_out.file_open = 1'b1;
				open_action = OPEN_READ;
			end
			OP_WRQ: begin
				rec_out.state = ST_WRITING;
				rec_out.block = '0;
				rec_out.file_open = 1'b1;
				open_action = OPEN_WRITE;
			end
			OP_DATA: begin
				if (rec_in.state == ST_WRITING && payload_length >= DATA_HDR_LEN && next_ok) begin
					write_block = rec_in.file_open;
					write_length = rec_in.file_open ? store_len : '0;
					rec_out.block = block_number;
					if (store_len < block_size) begin
						rec_out.state = ST_DONE;
						close_file = rec_in.file_open;
						rec_out.file_open = 1'b0;
					end
				end
			end
			OP_ACK: begin
				if (rec_in.state == ST_READING && block_number == rec_in.block) begin
					rec_out.block = rec_in.block + 16'd1;
				end
			end
			OP_ERROR: begin
				rec_out.state = ST_ERROR;
				close_file = rec_in.file_open;
				rec_out.file_open = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> verif/tftp_session_checker.sv
// ----------------------------------------------------------------------------
// TFTP session tracker checker
// Watches both channels and the configuration write port, keeps its own session table,
// and compares every result against the oldest predicted one.
// ----------------------------------------------------------------------------
module tftp_session_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic in_valid,
	input logic in_ready,
	input logic [31:0] peer_address,
	input logic [15:0] udp_port,
	input logic [15:0] opcode,
	input logic [15:0] block_number,
	input logic [15:0] payload_length,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] outcome,
	input logic [3:0] session_index,
	input logic session_created,
	input logic [2:0] session_state,
	input logic [15:0] current_block,
	input logic [1:0] open_action,
	input logic write_block,
	input logic [15:0] write_length,
	input logic close_file,
	output int mismatches,
	output int results_due
);
	import tst_pkg::*;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		outcome_t outcome;
		logic [3:0] index;
		logic created;
		sess_state_t state;
		logic [15:0] block;
		open_act_t open_act;
		logic wr;
		logic [15:0] wr_len;
		logic close;
	} session_result_t;

	logic [31:0] slot_addr [SESSION_SLOTS];
	logic [15:0] slot_port [SESSION_SLOTS];
	sess_state_t slot_state [SESSION_SLOTS];
	logic [15:0] slot_block [SESSION_SLOTS];
	logic slot_open [SESSION_SLOTS];
	int slots_used;
	logic [15:0] block_size;
	session_result_t expected_results [$];
	session_result_t want;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] wanted);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t session check: %s got %0h expected %0h", $time, what, got, wanted);
		end
		mismatches++;
	endtask

	// Advances the session table by one packet and returns the result it causes.
	function automatic session_result_t track_packet(input logic [31:0] addr,
		input logic [15:0] port, input logic [15:0] op, input logic [15:0] blk,
		input logic [15:0] len);
		session_result_t r;
		int slot;
		bit hit;
		logic [15:0] store_len;
		r = '0;
		slot = 0;
		hit = 1'b0;
		if (len < MIN_PACKET_LEN) begin
			r.outcome = OUT_SHORT;
			return r;
		end
		for (int i = 0; i < slots_used; i++) begin
			if (!hit && slot_addr[i] == addr && slot_port[i] == port) begin
				slot = i;
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (slots_used >= SESSION_SLOTS) begin
				r.outcome = OUT_FULL;
				return r;
			end
			slot = slots_used;
			slots_used++;
			slot_addr[slot] = addr;
			slot_port[slot] = port;
			slot_state[slot] = ST_IDLE;
			slot_block[slot] = 16'd0;
			slot_open[slot] = 1'b0;
			r.created = 1'b1;
		end
		case (op)
			OP_RRQ: begin
				slot_state[slot] = ST_READING;
				slot_block[slot] = 16'd1;
				slot_open[slot] = 1'b1;
				r.open_act = OPEN_READ;
			end
			OP_WRQ: begin
				slot_state[slot] = ST_WRITING;
				slot_block[slot] = 16'd0;
				slot_open[slot] = 1'b1;
				r.open_act = OPEN_WRITE;
			end
			OP_DATA: begin
				// The next block is expected without wrap, so nothing follows 65535.
				if (slot_state[slot] == ST_WRITING && len >= DATA_HDR_LEN &&
					{1'b0, blk} == {1'b0, slot_block[slot]} + 17'd1) begin
					store_len = len - DATA_HDR_LEN;
					if (slot_open[slot]) begin
						r.wr = 1'b1;
						r.wr_len = store_len;
					end
					slot_block[slot] = blk;
					if (store_len < block_size) begin
						slot_state[slot] = ST_DONE;
						if (slot_open[slot]) begin
							r.close = 1'b1;
							slot_open[slot] = 1'b0;
						end
					end
				end
			end
			OP_ACK: begin
				if (slot_state[slot] == ST_READING && blk == slot_block[slot]) begin
					slot_block[slot] = slot_block[slot] + 16'd1;
				end
			end
			OP_ERROR: begin
				slot_state[slot] = ST_ERROR;
				if (slot_open[slot]) begin
					r.close = 1'b1;
					slot_open[slot] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.outcome = OUT_HANDLED;
		r.index = 4'(slot);
		r.state = slot_state[slot];
		r.block = slot_block[slot];
		return r;
	endfunction

	// Results are compared before the new packet is predicted, so a result and
	// an input transaction on the same edge never see each other.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			slots_used = 0;
			block_size = BLOCK_SIZE_RESET;
			results_due = 0;
		end else begin
			if (cfg_we) begin
				block_size = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with none pending, outcome", outcome, 0);
				end else begin
					want = expected_results.pop_front();
					if (outcome !== want.outcome)
						flag_mismatch("outcome", outcome, want.outcome);
					if (session_index !== want.index)
						flag_mismatch("session_index", session_index, want.index);
					if (session_created !== want.created)
						flag_mismatch("session_created", session_created, want.created);
					if (session_state !== want.state)
						flag_mismatch("session_state", session_state, want.state);
					if (current_block !== want.block)
						flag_mismatch("current_block", current_block, want.block);
					if (open_action !== want.open_act)
						flag_mismatch("open_action", open_action, want.open_act);
					if (write_block !== want.wr)
						flag_mismatch("write_block", write_block, want.wr);
					if (write_length !== want.wr_len)
						flag_mismatch("write_length", write_length, want.wr_len);
					if (close_file !== want.close)
						flag_mismatch("close_file", close_file, want.close);
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(track_packet(peer_address, udp_port, opcode,
					block_number, payload_length));
			end
			results_due = expected_results.size();
		end
	end

endmodule

>>> verif/tb_tftp_session_tracker.sv
// ----------------------------------------------------------------------------
// TFTP session tracker testbench
// Drives packet transactions with random idling and long output stalls,
// walks the block size through its extremes, and lets the checker judge.
// ----------------------------------------------------------------------------
module tb_tftp_session_tracker;
	import tst_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 11;
	localparam int PHASE_PACKETS = 200;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int WATCHDOG_DELAY = 100000000;
	localparam int POOL_SIZE = SESSION_SLOTS;
	localparam int ZERO_SIZE_RUN = 12;

	// Opcodes the block has to ignore.
	localparam logic [15:0] OP_UNKNOWN_ZERO = 16'd0;
	localparam logic [15:0] OP_UNKNOWN_NEXT = 16'd6;
	localparam logic [15:0] OP_UNKNOWN_TOP = 16'hFFFF;

	// What the stimulus believes a peer is in the middle of.
	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_READ,
		RUN_WRITE
	} run_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [31:0] peer_address;
	logic [15:0] udp_port;
	logic [15:0] opcode;
	logic [15:0] block_number;
	logic [15:0] payload_length;
	logic out_valid;
	logic out_ready;
	logic [1:0] outcome;
	logic [3:0] session_index;
	logic session_created;
	logic [2:0] session_state;
	logic [15:0] current_block;
	logic [1:0] open_action;
	logic write_block;
	logic [15:0] write_length;
	logic close_file;

	int mismatches;
	int results_due;

	// Idling switch shared by both sides, and the request for one long stall.
	bit idle_on = 1'b1;
	bit hold_out = 1'b0;

	// The peers that own the sixteen slots, with the transfer each one is running.
	logic [31:0] pool_addr [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];
	run_kind_t run_kind [POOL_SIZE];
	logic [15:0] run_next [POOL_SIZE];
	int run_left [POOL_SIZE];
	int block_size_now = BLOCK_SIZE_RESET;

	always #HALF_PERIOD clk = ~clk;

	tftp_session_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.peer_address(peer_address),
		.udp_port(udp_port),
		.opcode(opcode),
		.block_number(block_number),
		.payload_length(payload_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.session_index(session_index),
		.session_created(session_created),
		.session_state(session_state),
		.current_block(current_block),
		.open_action(open_action),
		.write_block(write_block),
		.write_length(write_length),
		.close_file(close_file)
	);

	tftp_session_checker session_watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.peer_address(peer_address),
		.udp_port(udp_port),
		.opcode(opcode),
		.block_number(block_number),
		.payload_length(payload_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.session_index(session_index),
		.session_created(session_created),
		.session_state(session_state),
		.current_block(current_block),
		.open_action(open_action),
		.write_block(write_block),
		.write_length(write_length),
		.close_file(close_file),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	// Offers one packet and returns at the edge where the transaction happens.
	// The caller is then at that edge, so the next packet can follow at once
	// without valid dropping in between.
	task automatic send_packet(input logic [31:0] addr, input logic [15:0] port,
		input logic [15:0] op, input logic [15:0] blk, input logic [15:0] len);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		peer_address <= addr;
		udp_port <= port;
		opcode <= op;
		block_number <= blk;
		payload_length <= len;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering and waits until every predicted result has been taken.
	// The count is read on the falling edge, away from the checker's updates.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		@(posedge clk);
	endtask

	// The register is only written with the block empty; a settling wait then
	// lets any work behind the last result finish first.
	task automatic load_block_size(input logic [15:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		block_size_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed transfers: a request, then in-order DATA or ACK with
	// full blocks and a short block to finish a write. About one packet in
	// eight is noise: odd opcodes, stale or skipped blocks, short lengths, and
	// strangers that find the table full.
	task automatic run_random(input int count);
		int k;
		int p;
		int lo;
		int hi;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] op;
		logic [15:0] blk;
		logic [15:0] len;
		for (k = 0; k < count; k++) begin
			// While idling is on, the sender pauses once per phase until the block has drained.
			if (k == count / 4 && idle_on) begin
				wait_drained();
			end
			// The receiver goes quiet for a long stretch while packets keep coming.
			if (k == count / 2 && idle_on) begin
				hold_out = 1'b1;
			end
			p = $urandom_range(0, POOL_SIZE - 1);
			addr = pool_addr[p];
			port = pool_port[p];
			blk = run_next[p];
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 3) == 0) begin
					addr = $urandom;
					port = 16'($urandom);
				end
				case ($urandom_range(0, 3))
					0: op = 16'($urandom_range(0, 7));
					1: op = 16'($urandom);
					2: op = OP_DATA;
					default: op = OP_ACK;
				endcase
				case ($urandom_range(0, 3))
					0: blk = run_next[p] - 16'd1;
					1: blk = run_next[p] + 16'd1;
					2: blk = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
					default: blk = 16'($urandom);
				endcase
				len = $urandom_range(0, 1) ? 16'($urandom_range(0, 5)) : 16'($urandom);
			end else if (run_kind[p] == RUN_NONE) begin
				op = $urandom_range(0, 1) ? OP_RRQ : OP_WRQ;
				blk = 16'($urandom);
				len = 16'($urandom_range(2, 100));
				run_kind[p] = (op == OP_RRQ) ? RUN_READ : RUN_WRITE;
				run_next[p] = 16'd1;
				run_left[p] = $urandom_range(1, 8);
			end else begin
				op = (run_kind[p] == RUN_READ) ? OP_ACK : OP_DATA;
				if (run_kind[p] == RUN_WRITE && run_left[p] == 1 && block_size_now > 0) begin
					len = 16'($urandom_range(4, block_size_now + 3));
				end else if ($urandom_range(0, 9) == 0) begin
					len = 16'hFFFF;
				end else begin
					lo = block_size_now + 4;
					hi = (lo + 40 > 65535) ? 65535 : lo + 40;
					len = 16'($urandom_range(lo, hi));
				end
				run_next[p] = run_next[p] + 16'd1;
				run_left[p]--;
				if (run_left[p] == 0) begin
					run_kind[p] = RUN_NONE;
				end
			end
			send_packet(addr, port, op, blk, len);
		end
	endtask

	// Output side: ready most of the time, random short stalls
	// while idling is on, and one long stall whenever the stimulus asks.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int n;
		int waited;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		peer_address <= '0;
		udp_port <= '0;
		opcode <= '0;
		block_number <= '0;
		payload_length <= '0;

		// The pool holds both address extremes, two peers that share an address
		// and two that share a port, so matching must use both fields.
		for (n = 0; n < POOL_SIZE; n++) begin
			pool_addr[n] = $urandom;
			pool_port[n] = 16'($urandom);
			run_kind[n] = RUN_NONE;
			run_next[n] = 16'd1;
			run_left[n] = 0;
		end
		pool_addr[0] = 32'h0000_0000;
		pool_port[0] = 16'h0000;
		pool_addr[1] = 32'hFFFF_FFFF;
		pool_port[1] = 16'hFFFF;
		pool_addr[3] = pool_addr[2];
		pool_port[3] = pool_port[2] ^ 16'h0001;
		pool_addr[5] = pool_addr[4] ^ 32'h8000_0000;
		pool_port[5] = pool_port[4];

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Packets below two bytes are dropped without touching the session table.
		send_packet(pool_addr[15], pool_port[15], OP_RRQ, 16'd0, 16'd0);
		send_packet(pool_addr[15], pool_port[15], OP_RRQ, 16'd0, 16'd1);
		// A read session: open, one good ACK, a stray ACK, DATA in the wrong state.
		send_packet(pool_addr[0], pool_port[0], OP_RRQ, 16'd0, 16'd2);
		send_packet(pool_addr[0], pool_port[0], OP_ACK, 16'd1, 16'd4);
		send_packet(pool_addr[0], pool_port[0], OP_ACK, 16'hFFFF, 16'd4);
		send_packet(pool_addr[0], pool_port[0], OP_DATA, 16'd3, 16'd516);
		// A write session: short DATA is ignored, out of order is ignored, then
		// a full block, the longest block, ACK in the wrong state and an empty
		// block that ends the transfer.
		send_packet(pool_addr[1], pool_port[1], OP_WRQ, 16'hFFFF, 16'hFFFF);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd1, 16'd3);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd2, 16'd516);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd1, 16'd516);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd2, 16'hFFFF);
		send_packet(pool_addr[1], pool_port[1], OP_ACK, 16'd2, 16'd4);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd3, 16'd4);
		send_packet(pool_addr[1], pool_port[1], OP_DATA, 16'd4, 16'd516);
		// Requests on existing sessions restart them without a close.
		send_packet(pool_addr[1], pool_port[1], OP_RRQ, 16'd0, 16'd20);
		send_packet(pool_addr[0], pool_port[0], OP_WRQ, 16'd0, 16'd20);
		// ERROR closes an open file once only.
		send_packet(pool_addr[0], pool_port[0], OP_ERROR, 16'd0, 16'd5);
		send_packet(pool_addr[0], pool_port[0], OP_ERROR, 16'd0, 16'd5);
		// Unknown opcodes only allocate; ERROR on a fresh session has nothing to close.
		send_packet(pool_addr[2], pool_port[2], OP_UNKNOWN_ZERO, 16'd0, 16'd4);
		send_packet(pool_addr[3], pool_port[3], OP_UNKNOWN_TOP, 16'd0, 16'd4);
		send_packet(pool_addr[2], pool_port[2], OP_ERROR, 16'd0, 16'd4);
		send_packet(pool_addr[4], pool_port[4], OP_ACK, 16'd0, 16'd4);
		send_packet(pool_addr[5], pool_port[5], OP_UNKNOWN_NEXT, 16'd0, 16'h8000);

		// Every pool peer starts a transfer, which fills the table; a stranger
		// then finds no free slot.
		for (n = 0; n < POOL_SIZE; n++) begin
			run_kind[n] = (n % 2 == 0) ? RUN_READ : RUN_WRITE;
			run_next[n] = 16'd1;
			run_left[n] = $urandom_range(1, 8);
			send_packet(pool_addr[n], pool_port[n], (n % 2 == 0) ? OP_RRQ : OP_WRQ,
				16'd0, 16'd30);
		end
		send_packet(32'hC0A8_0001, 16'd69, OP_RRQ, 16'd0, 16'd30);

		// Random phases across block sizes, from the reset value through both
		// extremes and zero.
		run_random(PHASE_PACKETS);
		load_block_size(16'd1);
		run_random(PHASE_PACKETS);
		load_block_size(16'd65464);
		run_random(PHASE_PACKETS);

		// With a zero block size no block is short, so even empty blocks keep a
		// write going, and a stale block zero is still refused. A read session
		// then acknowledges a run of blocks.
		load_block_size(16'd0);
		idle_on = 1'b0;
		send_packet(pool_addr[6], pool_port[6], OP_WRQ, 16'd0, 16'd20);
		for (n = 1; n <= ZERO_SIZE_RUN; n++) begin
			send_packet(pool_addr[6], pool_port[6], OP_DATA, 16'(n), DATA_HDR_LEN);
		end
		send_packet(pool_addr[6], pool_port[6], OP_DATA, 16'h0000, 16'd516);
		send_packet(pool_addr[6], pool_port[6], OP_DATA, 16'hFFFF, 16'd516);
		send_packet(pool_addr[7], pool_port[7], OP_RRQ, 16'd0, 16'd20);
		for (n = 1; n <= ZERO_SIZE_RUN; n++) begin
			send_packet(pool_addr[7], pool_port[7], OP_ACK, 16'(n), 16'd4);
		end
		run_kind[6] = RUN_NONE;
		run_kind[7] = RUN_NONE;
		idle_on = 1'b1;
		run_random(PHASE_PACKETS);

		load_block_size(16'($urandom_range(2, 1500)));
		run_random(PHASE_PACKETS);

		// The last phase runs with no idling on either side.
		load_block_size(BLOCK_SIZE_RESET);
		idle_on = 1'b0;
		run_random(PHASE_PACKETS);

		// Wait for every outstanding result, with a limit, then let the block settle
		// to catch any result that should not be there.
		in_valid <= 1'b0;
		for (waited = 0; results_due != 0 && waited < DRAIN_LIMIT; waited++) begin
			@(negedge clk);
		end
		if (results_due != 0) begin
			$display("tftp_session_tracker: mismatch");
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (mismatches == 0) begin
				$display("tftp_session_tracker: match");
			end else begin
				$display("tftp_session_tracker: mismatch");
			end
		end
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin
		#WATCHDOG_DELAY;
		$display("tftp_session_tracker: mismatch");
		$finish;
	end

endmodule
